// File: src/cpr_pkg.sv
// shared types, constants and check function for the calibration packet receiver
`default_nettype none

package cpr_pkg;

    localparam int PACKET_BYTES = 68;
    localparam int CHECK_START  = 66;
    localparam int WORDS_START  = 26;
    localparam int WORD_COUNT   = 10;
    localparam int POS_W        = 7;
    localparam int IDX_W        = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 8;

    localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_WORDS  = POS_W'(WORDS_START);
    localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(CHECK_START);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PACKET_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(WORD_COUNT - 1);

    localparam logic [15:0] CHECK_POLY = 16'hA001;
    localparam logic [15:0] CHECK_INIT = 16'hFFFF;

    localparam logic [7:0] SIG_FIRST_RESET  = 8'd117;
    localparam logic [7:0] SIG_SECOND_RESET = 8'd84;

    localparam logic [CFG_INDEX_W-1:0] CFG_SIG_FIRST  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SIG_SECOND = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] word_index;
        logic [31:0]      word_value;
        logic             crc_error;
        logic             last;
    } result_t;

    typedef struct packed {
        logic crc_error;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    function automatic logic [15:0] check_update(input logic [15:0] c_in,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CHECK_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/cpr_stream_if.sv
// valid/ready channel carrying one payload per request
`default_nettype none

interface cpr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/cpr_fifo.sv
// short job queue between the front and back parts
`default_nettype none

module cpr_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cpr_stream_if.sink    push,
    cpr_stream_if.source  pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push.ready  = (count_reg != CNT_W'(DEPTH));
    assign pop.valid   = (count_reg != CNT_W'(0));
    assign pop.payload = mem_reg[rd_ptr_reg];
    assign do_push     = push.valid && push.ready;
    assign do_pop      = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.payload;
    end

endmodule

`default_nettype wire

// File: src/cpr_front.sv
// front part: signature hunt, byte position, running check and word capture
`default_nettype none

module cpr_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  sig_first,
    input  wire logic [7:0]  sig_second,
    input  wire logic        lock,
    cpr_stream_if.sink       rx,
    cpr_stream_if.source     job,
    output logic [31:0]      words [cpr_pkg::WORD_COUNT]
);

    logic [cpr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]               crc_reg, crc_next;
    logic [7:0]                low_reg, low_next;
    logic [31:0]               word_reg [cpr_pkg::WORD_COUNT];
    logic [7:0]                b;
    logic                      accept;
    logic                      in_words;
    logic                      word_stall;
    logic [cpr_pkg::POS_W-1:0] offset;
    logic [cpr_pkg::IDX_W-1:0] wsel;
    logic [1:0]                lane;

    assign b          = rx.payload.rx_byte;
    assign in_words   = (pos_reg >= cpr_pkg::POS_WORDS) && (pos_reg < cpr_pkg::POS_CHECK);
    assign word_stall = lock && in_words;
    assign rx.ready   = (pos_reg == cpr_pkg::POS_LAST) ? job.ready : !word_stall;
    assign accept     = rx.valid && rx.ready;

    assign job.valid             = rx.valid && (pos_reg == cpr_pkg::POS_LAST);
    assign job.payload.crc_error = (crc_reg != {b, low_reg});

    assign offset = pos_reg - cpr_pkg::POS_WORDS;
    assign wsel   = offset[cpr_pkg::IDX_W+1:2];
    assign lane   = offset[1:0];
    assign words  = word_reg;

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        low_next = low_reg;
        if (accept)
        begin
            priority if (pos_reg == cpr_pkg::POS_FIRST)
            begin
                if (b == sig_first)
                begin
                    crc_next = cpr_pkg::check_update(cpr_pkg::CHECK_INIT, b);
                    pos_next = cpr_pkg::POS_SECOND;
                end
            end
            else if (pos_reg == cpr_pkg::POS_SECOND)
            begin
                if (b == sig_second)
                begin
                    crc_next = cpr_pkg::check_update(crc_reg, b);
                    pos_next = pos_reg + cpr_pkg::POS_W'(1);
                end
                else
                begin
                    crc_next = cpr_pkg::CHECK_INIT;
                    pos_next = cpr_pkg::POS_FIRST;
                end
            end
            else if (pos_reg < cpr_pkg::POS_CHECK)
            begin
                crc_next = cpr_pkg::check_update(crc_reg, b);
                pos_next = pos_reg + cpr_pkg::POS_W'(1);
            end
            else if (pos_reg == cpr_pkg::POS_CHECK)
            begin
                low_next = b;
                pos_next = pos_reg + cpr_pkg::POS_W'(1);
            end
            else
            begin
                crc_next = cpr_pkg::CHECK_INIT;
                pos_next = cpr_pkg::POS_FIRST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= cpr_pkg::POS_FIRST;
            crc_reg <= cpr_pkg::CHECK_INIT;
            low_reg <= 8'h00;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            low_reg <= low_next;
        end
    end

    // capture word bytes in place, little-endian
    always_ff @(posedge clk)
    begin
        if (accept && in_words)
            word_reg[wsel][lane*8 +: 8] <= b;
    end

endmodule

`default_nettype wire

// File: src/cpr_back.sv
// back part: drains one job into result requests through an output register
`default_nettype none

module cpr_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [31:0]  words [cpr_pkg::WORD_COUNT],
    cpr_stream_if.sink        job,
    cpr_stream_if.source      result,
    output logic              busy
);

    cpr_pkg::back_state_t      state_reg, state_next;
    logic [cpr_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      err_reg, err_next;
    logic                      out_valid_reg, out_valid_next;
    cpr_pkg::result_t          out_reg, out_next;
    logic                      slot_free;
    logic                      load;
    logic                      is_last;

    assign slot_free = !out_valid_reg || result.ready;
    assign is_last   = err_reg || (idx_reg == cpr_pkg::IDX_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpr_pkg::BK_IDLE:
            begin
                if (job.valid)
                    state_next = cpr_pkg::BK_RUN;
            end
            cpr_pkg::BK_RUN:
            begin
                if (slot_free && is_last)
                    state_next = cpr_pkg::BK_IDLE;
            end
            default:
                state_next = cpr_pkg::BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        job.ready      = 1'b0;
        load           = 1'b0;
        idx_next       = idx_reg;
        err_next       = err_reg;
        unique case (state_reg)
            cpr_pkg::BK_IDLE:
            begin
                job.ready = 1'b1;
                if (job.valid)
                begin
                    idx_next = '0;
                    err_next = job.payload.crc_error;
                end
            end
            cpr_pkg::BK_RUN:
            begin
                if (slot_free)
                begin
                    load     = 1'b1;
                    idx_next = idx_reg + cpr_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                job.ready = 1'b0;
            end
        endcase

        out_next            = out_reg;
        out_valid_next      = out_valid_reg && !result.ready;
        if (load)
        begin
            out_valid_next      = 1'b1;
            out_next.word_index = err_reg ? '0 : idx_reg;
            out_next.word_value = err_reg ? 32'h0 : words[idx_reg];
            out_next.crc_error  = err_reg;
            out_next.last       = is_last;
        end
    end

    assign busy           = (state_reg == cpr_pkg::BK_RUN);
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        err_reg <= err_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// File: src/calibration_packet_receiver_top.sv
// top level of the calibration packet receiver
//
// rx carries one received byte per request; result carries calibration words.
// the block hunts for the two signature bytes set by registers 0 and 1 of the
// write port (cfg_we, cfg_index, cfg_data), then collects a 68-byte packet and
// checks its crc-16 (reflected 0xa001, start 0xffff) against bytes 66 and 67.
// a good packet gives ten results, words 0 to 9 with last on word 9; a bad one
// gives a single result with crc_error and last set.
// rx takes one byte per cycle unless held back as below. the final byte
// pushes a job to the queue; the back part loads the first result, and its
// single output register then drains one word per cycle while result is ready.
// a two-entry job queue parts the byte front from the result back, so bytes
// keep flowing while words drain; only bytes 26 to 65 of the next packet wait
// while the previous run still reads the captured words.
// when the receiver stalls, the pending result holds and the back part waits.
// reset returns to hunting, empties the queue and restores the signature
// bytes to 117 and 84.
`default_nettype none

module calibration_packet_receiver_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    cpr_stream_if.sink                            rx,
    cpr_stream_if.source                          result
);

    logic [7:0]  sig_first_reg;
    logic [7:0]  sig_second_reg;
    logic [31:0] words [cpr_pkg::WORD_COUNT];
    logic        busy;
    logic        lock;

    cpr_stream_if #(.T(cpr_pkg::job_t)) job_push ();
    cpr_stream_if #(.T(cpr_pkg::job_t)) job_pop ();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_first_reg  <= cpr_pkg::SIG_FIRST_RESET;
            sig_second_reg <= cpr_pkg::SIG_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpr_pkg::CFG_SIG_FIRST:  sig_first_reg  <= cfg_data;
                cpr_pkg::CFG_SIG_SECOND: sig_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign lock = busy || job_pop.valid;

    cpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sig_first  (sig_first_reg),
        .sig_second (sig_second_reg),
        .lock       (lock),
        .rx         (rx),
        .job        (job_push),
        .words      (words)
    );

    cpr_fifo #(
        .T     (cpr_pkg::job_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .pop   (job_pop)
    );

    cpr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .words  (words),
        .job    (job_pop),
        .result (result),
        .busy   (busy)
    );

endmodule

`default_nettype wire

// File: src/cpr_checker.sv
// port-level assertions for the calibration packet receiver and their bind
`default_nettype none

module cpr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [cpr_pkg::IDX_W-1:0]     res_word_index,
    input wire logic [31:0]                   res_word_value,
    input wire logic                          res_crc_error,
    input wire logic                          res_last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_word_index)
            && $stable(res_word_value) && $stable(res_crc_error) && $stable(res_last))
        else $error("stalled result changed");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_crc_error |-> res_last && (res_word_index == '0)
            && (res_word_value == 32'h0))
        else $error("error result not a lone zero result");

    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_crc_error |-> (res_last == (res_word_index == cpr_pkg::IDX_LAST)))
        else $error("last flag out of step with word index");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_word_index <= cpr_pkg::IDX_LAST))
        else $error("word index out of range");

endmodule

bind calibration_packet_receiver_top cpr_checker u_cpr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_word_index (result.payload.word_index),
    .res_word_value (result.payload.word_value),
    .res_crc_error  (result.payload.crc_error),
    .res_last       (result.payload.last)
);

`default_nettype wire
